// File: design/assert_macros.svh
// Assertion macros for the RTL files (included by the walker).
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CHK_IMPL(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion check failed");
`define CHK_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("assertion check failed");
`else
`define CHK_IMPL(lbl, clk, rstn, prop)
`define CHK_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: design/didsw_pkg.sv
// ----------------------------------------------------------------------------
// didsw_pkg
// Types and fixed constants of the DisplayID section walker.
// ----------------------------------------------------------------------------
package didsw_pkg;

	localparam int SECTION_BYTES = 128;
	localparam logic [6:0] LAST_POS = 7'(SECTION_BYTES - 1);
	localparam logic [6:0] FIRST_BLOCK = 7'd5;
	localparam logic [7:0] VER_2X = 8'h20;
	localparam logic [7:0] TYPE_MAX_V1 = 8'd6;
	localparam logic [7:0] TYPE_MAX_V2 = 8'd8;

	// header byte positions
	localparam logic [6:0] POS_MAGIC = 7'd0;
	localparam logic [6:0] POS_VERSION = 7'd1;
	localparam logic [6:0] POS_LENGTH = 7'd2;
	localparam logic [6:0] POS_TYPE = 7'd3;
	localparam logic [6:0] POS_EXT = 7'd4;

	localparam logic [1:0] EV_HEADER = 2'd0;
	localparam logic [1:0] EV_BLOCK = 2'd1;
	localparam logic [1:0] EV_STATUS = 2'd2;

	localparam logic [1:0] WS_OK = 2'd0;
	localparam logic [1:0] WS_SHORT_TAIL = 2'd1;
	localparam logic [1:0] WS_OVERRUN = 2'd2;
	localparam logic [1:0] WS_FILLER = 2'd3;

	typedef enum logic [6:0] {
		PH_HEADER  = 7'b0000001,
		PH_TAG     = 7'b0000010,
		PH_SECOND  = 7'b0000100,
		PH_LEN     = 7'b0001000,
		PH_PAYLOAD = 7'b0010000,
		PH_FILLER  = 7'b0100000,
		PH_DONE    = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       section_start;
	} item_t;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [7:0] version;
		logic [7:0] section_length;
		logic [7:0] use_case;
		logic       use_case_known;
		logic [7:0] extension_count;
		logic [7:0] block_tag;
		logic [7:0] block_length;
		logic [6:0] block_offset;
		logic [1:0] walk_status;
		logic       checksum_ok;
		logic       padding_ok;
	} result_t;

endpackage

// File: design/didsw_in_stage.sv
// ----------------------------------------------------------------------------
// didsw_in_stage
// Input register: captures one byte per transfer ahead of the walker.
// ----------------------------------------------------------------------------
module didsw_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  didsw_pkg::item_t  in_item,
	input  logic              out_free,
	output logic              in_stall,
	output logic              valid_s1,
	output logic              proc_en,
	output didsw_pkg::item_t  item_s1
);

	logic load;

	// the held byte is consumed whenever the result register can take a result
	assign proc_en = valid_s1 & out_free;
	assign in_stall = valid_s1 & ~out_free;
	assign load = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (proc_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

endmodule

// File: design/didsw_walker.sv
// ----------------------------------------------------------------------------
// didsw_walker
// Section state and the per-byte header, block walk, checksum and padding logic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module didsw_walker #(
	parameter int MAX_WALK_LENGTH = 121
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  didsw_pkg::item_t   item,
	output logic               res_valid,
	output didsw_pkg::result_t res
);

	localparam int REM_W = $clog2(MAX_WALK_LENGTH + 1);
	localparam logic [7:0] MAX_LEN = 8'(MAX_WALK_LENGTH);
	localparam logic [REM_W-1:0] HDR3 = REM_W'(3);

	logic [6:0]           byte_pos_q;
	logic [7:0]           version_q;
	logic [7:0]           length_q;
	logic [7:0]           type_q;
	logic [REM_W-1:0]     rem_q;
	logic [6:0]           next_off_q;
	didsw_pkg::phase_t    phase_q;
	logic [7:0]           tag_q;
	logic                 tail_q;
	logic [1:0]           err_q;
	logic [7:0]           sum_q;
	logic                 pad_q;

	logic [7:0]           b;
	logic [6:0]           pos;
	logic [7:0]           len_eff;
	logic                 cks_in;
	logic [7:0]           sum_nxt;
	logic                 pad_nxt;
	logic [8:0]           total;
	logic [8:0]           rem_ext;
	logic [REM_W-1:0]     rem_after_blk;
	logic [REM_W-1:0]     rem_after_zero;
	logic [REM_W-1:0]     rem_dec;
	logic [7:0]           type_lim;
	logic                 hdr_ev;
	logic                 blk_ev;
	logic                 walk_err;
	logic                 pos_step;

	assign b = item.data_byte;
	assign pos = item.section_start ? didsw_pkg::POS_MAGIC : byte_pos_q;
	assign len_eff = (pos == didsw_pkg::POS_LENGTH) ? b : length_q;
	// checksum covers bytes 1 .. length+5, cut at the last byte
	assign cks_in = {2'b00, pos} <= ({1'b0, len_eff} + 9'd5);
	assign sum_nxt = cks_in ? sum_q + b : sum_q;
	assign pad_nxt = pad_q & ~(({2'b00, pos} >= ({1'b0, len_eff} + 9'd6))
		&& (pos != didsw_pkg::LAST_POS) && (b != 8'd0));
	assign total = {1'b0, b} + 9'd3;
	assign rem_ext = 9'(rem_q);
	assign rem_after_blk = rem_q - total[REM_W-1:0];
	assign rem_after_zero = rem_q - HDR3;
	assign rem_dec = (rem_q != '0) ? rem_q - REM_W'(1) : rem_q;
	assign type_lim = (version_q < didsw_pkg::VER_2X) ? didsw_pkg::TYPE_MAX_V1
		: didsw_pkg::TYPE_MAX_V2;

	always_comb begin
		res_valid = 1'b0;
		res = '0;
		if (pos == didsw_pkg::POS_EXT) begin
			res_valid = 1'b1;
			res.event_kind = didsw_pkg::EV_HEADER;
			res.version = version_q;
			res.section_length = length_q;
			res.use_case = type_q;
			res.use_case_known = type_q <= type_lim;
			res.extension_count = b;
		end else if (pos == didsw_pkg::LAST_POS) begin
			res_valid = 1'b1;
			res.event_kind = didsw_pkg::EV_STATUS;
			res.walk_status = err_q;
			res.checksum_ok = sum_nxt == 8'd0;
			res.padding_ok = pad_nxt;
		end else if (pos > didsw_pkg::POS_EXT && phase_q == didsw_pkg::PH_LEN
				&& rem_ext >= total && !(tag_q == 8'd0 && b == 8'd0)) begin
			res_valid = 1'b1;
			res.event_kind = didsw_pkg::EV_BLOCK;
			res.block_tag = tag_q;
			res.block_length = b;
			res.block_offset = next_off_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= '0;
			version_q <= '0;
			length_q <= '0;
			type_q <= '0;
			rem_q <= '0;
			next_off_q <= didsw_pkg::FIRST_BLOCK;
			phase_q <= didsw_pkg::PH_HEADER;
			tag_q <= '0;
			tail_q <= 1'b0;
			err_q <= didsw_pkg::WS_OK;
			sum_q <= '0;
			pad_q <= 1'b1;
		end else if (en) begin
			byte_pos_q <= pos + 7'd1;
			if (pos == didsw_pkg::POS_MAGIC) begin
				version_q <= '0;
				length_q <= '0;
				type_q <= '0;
				rem_q <= '0;
				next_off_q <= didsw_pkg::FIRST_BLOCK;
				phase_q <= didsw_pkg::PH_HEADER;
				tag_q <= '0;
				tail_q <= 1'b0;
				err_q <= didsw_pkg::WS_OK;
				sum_q <= '0;
				pad_q <= 1'b1;
			end else begin
				sum_q <= sum_nxt;
				pad_q <= pad_nxt;
				if (pos == didsw_pkg::POS_VERSION) begin
					version_q <= b;
				end else if (pos == didsw_pkg::POS_LENGTH) begin
					length_q <= b;
					rem_q <= (b > MAX_LEN) ? MAX_LEN[REM_W-1:0] : b[REM_W-1:0];
				end else if (pos == didsw_pkg::POS_TYPE) begin
					type_q <= b;
				end else if (pos == didsw_pkg::POS_EXT) begin
					next_off_q <= didsw_pkg::FIRST_BLOCK;
					phase_q <= (rem_q != '0) ? didsw_pkg::PH_TAG : didsw_pkg::PH_DONE;
				end else if (pos == didsw_pkg::LAST_POS) begin
					phase_q <= didsw_pkg::PH_DONE;
				end else begin
					case (phase_q)
						didsw_pkg::PH_TAG: begin
							tag_q <= b;
							phase_q <= didsw_pkg::PH_SECOND;
						end
						didsw_pkg::PH_SECOND: begin
							tail_q <= b != 8'd0;
							if (rem_q < HDR3) begin
								if (tag_q != 8'd0 || b != 8'd0) begin
									err_q <= didsw_pkg::WS_SHORT_TAIL;
								end
								phase_q <= didsw_pkg::PH_DONE;
							end else begin
								phase_q <= didsw_pkg::PH_LEN;
							end
						end
						didsw_pkg::PH_LEN: begin
							if (rem_ext < total) begin
								err_q <= didsw_pkg::WS_OVERRUN;
								phase_q <= didsw_pkg::PH_DONE;
							end else if (tag_q == 8'd0 && b == 8'd0) begin
								// zero block: rest of the walk must be filler
								if (tail_q) begin
									err_q <= didsw_pkg::WS_FILLER;
									phase_q <= didsw_pkg::PH_DONE;
								end else begin
									rem_q <= rem_after_zero;
									phase_q <= (rem_after_zero != '0) ? didsw_pkg::PH_FILLER
										: didsw_pkg::PH_DONE;
								end
							end else begin
								rem_q <= rem_after_blk;
								next_off_q <= next_off_q + total[6:0];
								if (b == 8'd0) begin
									phase_q <= (rem_after_blk != '0) ? didsw_pkg::PH_TAG
										: didsw_pkg::PH_DONE;
								end else begin
									phase_q <= didsw_pkg::PH_PAYLOAD;
								end
							end
						end
						didsw_pkg::PH_PAYLOAD: begin
							if (pos + 7'd1 == next_off_q) begin
								phase_q <= (rem_q != '0) ? didsw_pkg::PH_TAG
									: didsw_pkg::PH_DONE;
							end
						end
						didsw_pkg::PH_FILLER: begin
							if (b != 8'd0) begin
								err_q <= didsw_pkg::WS_FILLER;
								phase_q <= didsw_pkg::PH_DONE;
							end else begin
								rem_q <= rem_dec;
								if (rem_dec == '0) begin
									phase_q <= didsw_pkg::PH_DONE;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	assign hdr_ev = res_valid && res.event_kind == didsw_pkg::EV_HEADER;
	assign blk_ev = res_valid && res.event_kind == didsw_pkg::EV_BLOCK;
	assign walk_err = err_q != didsw_pkg::WS_OK;
	assign pos_step = en && !item.section_start;

	`CHK_IMPL(a_err_ends_walk, clk, arst_n, walk_err |-> (phase_q == didsw_pkg::PH_DONE))
	`CHK_IMPL(a_hdr_at_pos4, clk, arst_n, hdr_ev |-> (pos == didsw_pkg::POS_EXT))
	`CHK_IMPL(a_blk_offset, clk, arst_n, blk_ev |-> (res.block_offset >= didsw_pkg::FIRST_BLOCK))
	`CHK_IMPL(a_pos_count, clk, arst_n, pos_step |=> (byte_pos_q == 7'($past(byte_pos_q) + 7'd1)))

endmodule

// File: design/didsw_out_reg.sv
// ----------------------------------------------------------------------------
// didsw_out_reg
// Result register: holds one event until the receiver takes the transfer.
// ----------------------------------------------------------------------------
module didsw_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  didsw_pkg::result_t res_in,
	input  logic               out_stall,
	output logic               out_free,
	output logic               out_valid,
	output didsw_pkg::result_t res_q
);

	assign out_free = ~out_valid | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && out_free) begin
			res_q <= res_in;
		end
	end

endmodule

// File: design/displayid_section_walker_unit.sv
// ----------------------------------------------------------------------------
// displayid_section_walker_unit
// DisplayID section walker: header, data block and status events per section.
// ----------------------------------------------------------------------------
// Input channel: one section byte per transfer (in_valid / in_stall), with
// section_start marking byte 0. A section is 128 bytes; without a start mark
// the byte after byte 127 begins a new section.
// Output channel: one event per transfer (out_valid / out_stall): a header
// event at byte 4, a block event at the length byte of each valid data block,
// and a status event at byte 127. Other bytes give no event.
// Path: the byte sits in the input register and its event is captured in the
// result register, which drives out_valid.
// Throughput: one byte per cycle while no result waits; all per-byte work is
// compares, adds and subtracts between the two registers.
// Stall: while a result waits, the input register still takes one more byte,
// then in_stall rises until the result is taken.
// Reset: position counter at byte 0, walk state cleared, both channels empty.
// ----------------------------------------------------------------------------
module displayid_section_walker_unit #(
	parameter int MAX_WALK_LENGTH = 121
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       section_start,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] event_kind,
	output logic [7:0] version,
	output logic [7:0] section_length,
	output logic [7:0] use_case,
	output logic       use_case_known,
	output logic [7:0] extension_count,
	output logic [7:0] block_tag,
	output logic [7:0] block_length,
	output logic [6:0] block_offset,
	output logic [1:0] walk_status,
	output logic       checksum_ok,
	output logic       padding_ok
);

	didsw_pkg::item_t   in_item;
	didsw_pkg::item_t   item_s1;
	didsw_pkg::result_t res;
	didsw_pkg::result_t res_q;
	logic               valid_s1;
	logic               proc_en;
	logic               out_free;
	logic               res_valid;

	assign in_item.data_byte = data_byte;
	assign in_item.section_start = section_start;

	didsw_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_item  (in_item),
		.out_free (out_free),
		.in_stall (in_stall),
		.valid_s1 (valid_s1),
		.proc_en  (proc_en),
		.item_s1  (item_s1)
	);

	didsw_walker #(
		.MAX_WALK_LENGTH (MAX_WALK_LENGTH)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (proc_en),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	didsw_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (proc_en & res_valid & valid_s1),
		.res_in    (res),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign event_kind = res_q.event_kind;
	assign version = res_q.version;
	assign section_length = res_q.section_length;
	assign use_case = res_q.use_case;
	assign use_case_known = res_q.use_case_known;
	assign extension_count = res_q.extension_count;
	assign block_tag = res_q.block_tag;
	assign block_length = res_q.block_length;
	assign block_offset = res_q.block_offset;
	assign walk_status = res_q.walk_status;
	assign checksum_ok = res_q.checksum_ok;
	assign padding_ok = res_q.padding_ok;

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream test of the DisplayID section walker. Sections are built with
// real data block chains (clean walks, overruns, dirty filler, short tails,
// long length bytes, bad checksums, dirty padding), plus noise and cut-off
// sections. Every accepted byte goes through an in-bench walker model, and
// every event transfer is checked field by field against its prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import didsw_pkg::*;

	localparam int WALK_LIMIT = 121;
	localparam int TOTAL_BYTES = 1600;
	localparam int RUN_LIMIT = 10_000_000;

	typedef enum int {
		SH_CLEAN,
		SH_OVERRUN,
		SH_DIRTY_FILL,
		SH_SHORT_TAIL
	} walk_shape_e;

	logic clk;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] data_byte = 8'h00;
	logic section_start = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] event_kind;
	logic [7:0] version;
	logic [7:0] section_length;
	logic [7:0] use_case;
	logic use_case_known;
	logic [7:0] extension_count;
	logic [7:0] block_tag;
	logic [7:0] block_length;
	logic [6:0] block_offset;
	logic [1:0] walk_status;
	logic checksum_ok;
	logic padding_ok;

	displayid_section_walker_unit #(
		.MAX_WALK_LENGTH(WALK_LIMIT)
	) u_dut (.*);

	// stimulus and expectations
	item_t section_bytes[$];
	result_t pending_events[$];
	logic [7:0] sec [128];
	int gen_pos = 0;
	int bytes_queued = 0;
	int mismatches = 0;
	int events_seen = 0;
	int cyc = 0;
	logic steady;
	logic hold_off = 1'b0;

	// walker model state
	logic [6:0] w_pos;
	logic [7:0] w_version;
	logic [7:0] w_len;
	logic [7:0] w_type;
	logic [7:0] w_tag;
	int w_left;
	logic [6:0] w_next_off;
	phase_t w_phase;
	logic w_tail_nz;
	logic [1:0] w_status;
	logic [7:0] w_sum;
	logic w_pad_clean;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cyc <= cyc + 1;
	// steady marks the stretch in which neither side draws new random gaps
	assign steady = (cyc % 1024) < 160;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic clear_walk();
		w_version = 8'h00;
		w_len = 8'h00;
		w_type = 8'h00;
		w_tag = 8'h00;
		w_left = 0;
		w_next_off = FIRST_BLOCK;
		w_phase = PH_HEADER;
		w_tail_nz = 1'b0;
		w_status = WS_OK;
		w_sum = 8'h00;
		w_pad_clean = 1'b1;
	endtask

	// advance the walker model by one byte, queue the event it gives
	task automatic walk_byte(input logic [7:0] b, input logic start);
		logic [6:0] pos;
		int cks_last;
		int total;
		result_t ev;
		bit emit;
		pos = start ? POS_MAGIC : w_pos;
		w_pos = pos + 7'd1;
		ev = '0;
		emit = 1'b0;
		if (pos == POS_MAGIC) begin
			clear_walk();
			return;
		end
		if (pos == POS_LENGTH)
			w_len = b;
		cks_last = int'(w_len) + 5;
		if (cks_last > int'(LAST_POS))
			cks_last = int'(LAST_POS);
		if (int'(pos) <= cks_last)
			w_sum = w_sum + b;
		if (int'(pos) >= int'(w_len) + 6 && pos < LAST_POS && b != 8'h00)
			w_pad_clean = 1'b0;
		case (pos)
			POS_VERSION: w_version = b;
			POS_LENGTH: w_left = (int'(b) > WALK_LIMIT) ? WALK_LIMIT : int'(b);
			POS_TYPE: w_type = b;
			POS_EXT: begin
				ev.event_kind = EV_HEADER;
				ev.version = w_version;
				ev.section_length = w_len;
				ev.use_case = w_type;
				ev.use_case_known =
					w_type <= ((w_version < VER_2X) ? TYPE_MAX_V1 : TYPE_MAX_V2);
				ev.extension_count = b;
				emit = 1'b1;
				w_next_off = FIRST_BLOCK;
				w_phase = (w_left > 0) ? PH_TAG : PH_DONE;
			end
			LAST_POS: begin
				ev.event_kind = EV_STATUS;
				ev.walk_status = w_status;
				ev.checksum_ok = (w_sum == 8'h00);
				ev.padding_ok = w_pad_clean;
				emit = 1'b1;
				w_phase = PH_DONE;
			end
			default: begin
				case (w_phase)
					PH_TAG: begin
						w_tag = b;
						w_phase = PH_SECOND;
					end
					PH_SECOND: begin
						w_tail_nz = (b != 8'h00);
						// fewer than three walk bytes at the tag: walk stops here
						if (w_left < 3) begin
							if (w_tag != 8'h00 || b != 8'h00)
								w_status = WS_SHORT_TAIL;
							w_phase = PH_DONE;
						end else begin
							w_phase = PH_LEN;
						end
					end
					PH_LEN: begin
						total = int'(b) + 3;
						if (w_left < total) begin
							w_status = WS_OVERRUN;
							w_phase = PH_DONE;
						end else if (w_tag == 8'h00 && b == 8'h00) begin
							// zero block: the rest of the walk must be zero
							if (w_tail_nz) begin
								w_status = WS_FILLER;
								w_phase = PH_DONE;
							end else begin
								w_left = w_left - 3;
								w_phase = (w_left > 0) ? PH_FILLER : PH_DONE;
							end
						end else begin
							ev.event_kind = EV_BLOCK;
							ev.block_tag = w_tag;
							ev.block_length = b;
							ev.block_offset = w_next_off;
							emit = 1'b1;
							w_left = w_left - total;
							w_next_off = w_next_off + 7'(total);
							if (b == 8'h00)
								w_phase = (w_left > 0) ? PH_TAG : PH_DONE;
							else
								w_phase = PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						if (pos + 7'd1 == w_next_off)
							w_phase = (w_left > 0) ? PH_TAG : PH_DONE;
					end
					PH_FILLER: begin
						if (b != 8'h00) begin
							w_status = WS_FILLER;
							w_phase = PH_DONE;
						end else begin
							if (w_left > 0)
								w_left = w_left - 1;
							if (w_left == 0)
								w_phase = PH_DONE;
						end
					end
					default: ;
				endcase
			end
		endcase
		if (emit)
			pending_events.push_back(ev);
	endtask

	// fill sec[] with one section; first_len < 0 leaves the first block random
	task automatic build_section(input logic [7:0] ver, input logic [7:0] len,
			input logic [7:0] ptype, input logic [7:0] ext, input walk_shape_e shape,
			input bit fix_sum, input bit dirty_pad, input int first_len);
		int off;
		int left;
		int p;
		int k;
		int last;
		logic [7:0] sum;
		foreach (sec[i])
			sec[i] = 8'h00;
		sec[0] = 8'($urandom);
		sec[1] = ver;
		sec[2] = len;
		sec[3] = ptype;
		sec[4] = ext;
		left = (int'(len) > WALK_LIMIT) ? WALK_LIMIT : int'(len);
		off = int'(FIRST_BLOCK);
		while (left >= 3) begin
			p = $urandom_range(0, (left - 3 < 24) ? left - 3 : 24);
			if ($urandom_range(0, 9) == 0)
				p = left - 3;
			if (off == int'(FIRST_BLOCK) && first_len >= 0)
				p = first_len;
			sec[off] = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
			sec[off + 1] = 8'($urandom);
			sec[off + 2] = 8'(p);
			if (p > left - 3)
				break;
			for (k = 0; k < p; k++)
				sec[off + 3 + k] = 8'($urandom);
			off += p + 3;
			left -= p + 3;
			if ($urandom_range(0, 4) == 0)
				break;
		end
		case (shape)
			SH_OVERRUN: begin
				if (left >= 3) begin
					sec[off] = 8'($urandom_range(1, 255));
					sec[off + 2] = 8'($urandom_range(left - 2, 255));
				end
			end
			SH_DIRTY_FILL: begin
				if (left >= 3 && $urandom_range(0, 1) == 0)
					sec[off + 1] = 8'($urandom_range(1, 255));
				else if (left > 0)
					sec[off + $urandom_range(0, left - 1)] = 8'($urandom_range(1, 255));
			end
			SH_SHORT_TAIL: begin
				if (left >= 4) begin
					k = (left == 4) ? 1 : $urandom_range(1, 2);
					p = left - 3 - k;
					sec[off] = 8'($urandom_range(1, 255));
					sec[off + 1] = 8'($urandom);
					sec[off + 2] = 8'(p);
					for (int j = 0; j < p; j++)
						sec[off + 3 + j] = 8'($urandom);
					off += p + 3;
					left = k;
				end
				if (left > 0 && left < 3)
					sec[off] = 8'($urandom_range(1, 255));
			end
			default: ;
		endcase
		if (dirty_pad && len <= 8'd120)
			sec[$urandom_range(int'(len) + 6, 126)] = 8'($urandom_range(1, 255));
		last = int'(len) + 5;
		if (last > 127)
			last = 127;
		if (last < 127)
			sec[127] = 8'($urandom);
		if (int'(len) > WALK_LIMIT)
			sec[126] = 8'($urandom);
		if (fix_sum) begin
			sum = 8'h00;
			for (k = 1; k < last; k++)
				sum = sum + sec[k];
			sec[last] = 8'h00 - sum;
		end else begin
			sec[last] = 8'($urandom);
		end
	endtask

	// queue the first count bytes of sec[]; a section that does not line up
	// with the walker position always carries a start mark
	task automatic queue_bytes(input int count, input bit want_mark);
		item_t it;
		bit mark;
		mark = want_mark || gen_pos != 0;
		for (int i = 0; i < count; i++) begin
			it.data_byte = sec[i];
			it.section_start = mark && i == 0;
			section_bytes.push_back(it);
		end
		gen_pos = mark ? count % 128 : (gen_pos + count) % 128;
		bytes_queued += count;
	endtask

	function automatic string field_diffs(result_t e, result_t a);
		string s;
		s = "";
		if (e.event_kind !== a.event_kind)
			s = {s, $sformatf(" event_kind exp=%0h got=%0h", e.event_kind, a.event_kind)};
		if (e.version !== a.version)
			s = {s, $sformatf(" version exp=%0h got=%0h", e.version, a.version)};
		if (e.section_length !== a.section_length)
			s = {s, $sformatf(" section_length exp=%0h got=%0h",
				e.section_length, a.section_length)};
		if (e.use_case !== a.use_case)
			s = {s, $sformatf(" use_case exp=%0h got=%0h", e.use_case, a.use_case)};
		if (e.use_case_known !== a.use_case_known)
			s = {s, $sformatf(" use_case_known exp=%0h got=%0h",
				e.use_case_known, a.use_case_known)};
		if (e.extension_count !== a.extension_count)
			s = {s, $sformatf(" extension_count exp=%0h got=%0h",
				e.extension_count, a.extension_count)};
		if (e.block_tag !== a.block_tag)
			s = {s, $sformatf(" block_tag exp=%0h got=%0h", e.block_tag, a.block_tag)};
		if (e.block_length !== a.block_length)
			s = {s, $sformatf(" block_length exp=%0h got=%0h",
				e.block_length, a.block_length)};
		if (e.block_offset !== a.block_offset)
			s = {s, $sformatf(" block_offset exp=%0h got=%0h",
				e.block_offset, a.block_offset)};
		if (e.walk_status !== a.walk_status)
			s = {s, $sformatf(" walk_status exp=%0h got=%0h", e.walk_status, a.walk_status)};
		if (e.checksum_ok !== a.checksum_ok)
			s = {s, $sformatf(" checksum_ok exp=%0h got=%0h", e.checksum_ok, a.checksum_ok)};
		if (e.padding_ok !== a.padding_ok)
			s = {s, $sformatf(" padding_ok exp=%0h got=%0h", e.padding_ok, a.padding_ok)};
		return s;
	endfunction

	// byte driver: a transfer is predicted at the edge it happens on
	int send_gap = 0;
	item_t next_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'h00;
			section_start <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall)
				walk_byte(data_byte, section_start);
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (section_bytes.size() != 0) begin
					next_item = section_bytes.pop_front();
					data_byte <= next_item.data_byte;
					section_start <= next_item.section_start;
					in_valid <= 1'b1;
					send_gap <= steady ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// event monitor and receiver stall
	int recv_hold = 0;
	result_t got;
	result_t want;
	string diff;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_hold <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {event_kind, version, section_length, use_case, use_case_known,
					extension_count, block_tag, block_length, block_offset, walk_status,
					checksum_ok, padding_ok};
				events_seen++;
				if (pending_events.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: event with none predicted: %p", $time, got);
				end else begin
					want = pending_events.pop_front();
					diff = field_diffs(want, got);
					if (diff != "") begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: event mismatch:%s", $time, diff);
					end
				end
			end
			if (hold_off) begin
				out_stall <= 1'b1;
			end else if (recv_hold != 0) begin
				out_stall <= 1'b1;
				recv_hold <= recv_hold - 1;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				recv_hold <= pick_gap();
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// long receiver hold-off so the input side backs up and stalls
	initial begin
		while (events_seen < 12)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (300)
			@(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#RUN_LIMIT;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		logic [7:0] ver;
		logic [7:0] len;
		logic [7:0] ptype;
		logic [7:0] ext;
		walk_shape_e shape;
		int r;

		w_pos = POS_MAGIC;
		clear_walk();
		arst_n = 1'b0;

		// empty walk
		build_section(8'h12, 8'd0, 8'd0, 8'h00, SH_CLEAN, 1'b1, 1'b0, -1);
		queue_bytes(128, 1'b1);
		// one block spanning the full walk, top version and extension count
		build_section(8'hFF, 8'(WALK_LIMIT), 8'd8, 8'hFF, SH_CLEAN, 1'b1, 1'b0,
			WALK_LIMIT - 3);
		queue_bytes(128, 1'b1);
		// length byte past the walk limit, unknown type for a 1.x version
		build_section(8'h1F, 8'hFF, 8'd7, 8'h00, SH_CLEAN, 1'b1, 1'b0, -1);
		queue_bytes(128, 1'b1);
		// first block length 255 overruns, unknown type for a 2.x version
		build_section(8'h20, 8'd60, 8'd9, 8'h01, SH_CLEAN, 1'b1, 1'b0, 255);
		queue_bytes(128, 1'b1);
		build_section(8'h20, 8'd40, 8'd8, 8'h00, SH_DIRTY_FILL, 1'b1, 1'b0, -1);
		queue_bytes(128, 1'b1);
		// short tail, bad checksum, dirty padding
		build_section(8'h10, 8'd30, 8'd6, 8'h00, SH_SHORT_TAIL, 1'b0, 1'b1, -1);
		queue_bytes(128, 1'b1);
		build_section(8'h21, 8'd2, 8'd0, 8'h00, SH_SHORT_TAIL, 1'b1, 1'b0, -1);
		queue_bytes(128, 1'b1);
		build_section(8'h12, 8'd50, 8'd2, 8'h00, SH_OVERRUN, 1'b1, 1'b0, -1);
		queue_bytes(128, 1'b1);
		// restart in the middle of a section
		build_section(8'h12, 8'd90, 8'd3, 8'h00, SH_CLEAN, 1'b1, 1'b0, -1);
		queue_bytes(50, 1'b1);
		// wrap into the next section without a start mark
		build_section(8'h20, 8'd20, 8'd1, 8'h00, SH_CLEAN, 1'b1, 1'b0, -1);
		queue_bytes(128, 1'b1);
		build_section(8'h21, 8'd70, 8'd4, 8'h00, SH_CLEAN, 1'b1, 1'b0, -1);
		queue_bytes(128, 1'b0);

		while (bytes_queued < TOTAL_BYTES) begin
			case ($urandom_range(0, 5))
				0: ver = 8'h10;
				1: ver = 8'h12;
				2: ver = 8'h1F;
				3: ver = 8'h20;
				4: ver = 8'h21;
				default: ver = 8'($urandom);
			endcase
			r = $urandom_range(0, 9);
			if (r < 7)
				len = 8'($urandom_range(0, WALK_LIMIT));
			else if (r < 8)
				len = 8'($urandom_range(0, 8));
			else
				len = 8'($urandom_range(WALK_LIMIT + 1, 255));
			ptype = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 10)) : 8'($urandom);
			ext = ($urandom_range(0, 4) != 0) ? 8'h00 : 8'($urandom);
			shape = walk_shape_e'($urandom_range(0, 3));
			if ($urandom_range(0, 1) == 0)
				shape = SH_CLEAN;
			build_section(ver, len, ptype, ext, shape, $urandom_range(0, 6) != 0,
				$urandom_range(0, 6) == 0, -1);
			r = $urandom_range(0, 99);
			if (r < 75) begin
				queue_bytes(128, $urandom_range(0, 1));
			end else if (r < 88) begin
				foreach (sec[i])
					sec[i] = 8'($urandom);
				queue_bytes(128, $urandom_range(0, 1));
			end else begin
				queue_bytes($urandom_range(1, 127), 1'b1);
			end
		end

		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;

		while (section_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
